### sv/slt_pkg.sv
// Package for the slot table: field widths, operation codes, state and word types.
`timescale 1ns / 1ps

package slt_pkg;

	// Default table depth
	localparam int SLOTS_DEF = 128;

	// Word field widths
	localparam int OP_W   = 2;
	localparam int VAL_W  = 8;
	localparam int POS_W  = 7;
	localparam int SLOT_W = 7;
	localparam int CNT_W  = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_REM_RD,
		ST_REM_CHK,
		ST_DONE
	} state_t;

	// One stored table entry
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
	} ent_t;

	// Result word handed from the sequencer to the output register
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
		logic              empty_res;
	} res_t;

endpackage

### sv/slt_if.sv
// Handshake interfaces for the request and response channels of the slot table.
`timescale 1ns / 1ps

interface slt_in_if;
	logic                       valid;
	logic                       ready;
	logic [slt_pkg::OP_W-1:0]   operation;
	logic [slt_pkg::VAL_W-1:0]  value;
	logic [slt_pkg::POS_W-1:0]  position;

	modport source (output valid, operation, value, position, input ready);
	modport sink (input valid, operation, value, position, output ready);
endinterface

interface slt_out_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [slt_pkg::SLOT_W-1:0] slot;
	logic [slt_pkg::CNT_W-1:0]  count;
	logic                       empty_res;

	modport source (output valid, hit, slot, count, empty_res, input ready);
	modport sink (input valid, hit, slot, count, empty_res, output ready);
endinterface

### sv/slot_table_with_lookup_core.sv
// Top level of the slot table: entry memory, sequencer and output register.
`timescale 1ns / 1ps

// Slot table of SLOTS byte entries, each with a valid bit, and a count of valid
// entries. Insert puts the byte into the lowest free slot (dropped when full),
// remove frees the slot given by position, lookup returns the lowest valid slot
// holding the byte. Every request word gives one response word with the count and
// an empty flag as they stand afterwards. Entries live in a single-port memory
// that one compare unit walks one entry per cycle, so the time insert and lookup take
// from accept to response depends on where the scan stops; remove reads the entry
// and then checks it, and a bad opcode or out-of-range remove goes straight to the
// response. One request is worked on at a time; the response sits in an output
// register so the next request can be taken while it waits. After reset a clearing
// pass over all SLOTS entries zeroes the memory, and no request is taken during it.

module slot_table_with_lookup_core #(
	parameter int SLOTS = slt_pkg::SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	slt_in_if.sink   req,
	slt_out_if.source rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic          ram_en;
	logic          ram_we;
	logic [IW-1:0] ram_addr;
	slt_pkg::ent_t ram_wd;
	slt_pkg::ent_t ram_rd;

	logic          res_valid;
	logic          res_ready;
	slt_pkg::res_t res;

	logic          out_v_q;
	slt_pkg::res_t out_q;

	slt_ram #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	slt_seq #(
		.SLOTS (SLOTS),
		.IW    (IW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ram_en    (ram_en),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wd    (ram_wd),
		.ram_rd    (ram_rd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: loads when empty or being drained
	assign res_ready = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.hit       = out_q.hit;
	assign rsp.slot      = out_q.slot;
	assign rsp.count     = out_q.count;
	assign rsp.empty_res = out_q.empty_res;

endmodule

### sv/slt_ram.sv
// Single-port entry memory with registered read data.
`timescale 1ns / 1ps

module slt_ram #(
	parameter int DEPTH = slt_pkg::SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            en,
	input  logic            we,
	input  logic [AW-1:0]   addr,
	input  slt_pkg::ent_t   wdata,
	output slt_pkg::ent_t   rdata
);

	slt_pkg::ent_t mem_q [DEPTH];
	slt_pkg::ent_t rdata_q;

	// One access per cycle: write or read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/slt_seq.sv
// Sequencer: clearing pass, entry scan with the shared compare, remove and count upkeep.
`timescale 1ns / 1ps

module slt_seq #(
	parameter int SLOTS = slt_pkg::SLOTS_DEF,
	parameter int IW    = $clog2(SLOTS),
	parameter int CW    = $clog2(SLOTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	slt_in_if.sink        req,
	// entry memory port
	output logic          ram_en,
	output logic          ram_we,
	output logic [IW-1:0] ram_addr,
	output slt_pkg::ent_t ram_wd,
	input  slt_pkg::ent_t ram_rd,
	// result toward the output register
	output logic          res_valid,
	input  logic          res_ready,
	output slt_pkg::res_t res
);

	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	slt_pkg::state_t st_q, st_d;

	logic [IW-1:0]                rd_idx_q;
	logic                         issue_q;
	logic                         chk_q;
	logic [IW-1:0]                chk_idx_q;
	logic [CW-1:0]                cnt_q;
	logic [slt_pkg::OP_W-1:0]     op_q;
	logic [slt_pkg::VAL_W-1:0]    val_q;
	logic [IW-1:0]                pos_q;
	logic                         hit_q;
	logic [IW-1:0]                slot_q;

	logic accept;
	logic pos_ok;
	logic found;
	logic scan_hit;

	assign accept   = req.valid && req.ready;
	assign pos_ok   = int'(req.position) < SLOTS;
	// shared compare: free slot for insert, valid match for lookup
	assign found    = (op_q == slt_pkg::OP_INSERT) ? !ram_rd.valid :
	                  (ram_rd.valid && (ram_rd.value == val_q));
	assign scan_hit = chk_q && found;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= slt_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		st_d         = st_q;
		req.ready    = 1'b0;
		ram_en       = 1'b0;
		ram_we       = 1'b0;
		ram_addr     = rd_idx_q;
		ram_wd       = '0;
		res_valid    = 1'b0;
		case (st_q)
			slt_pkg::ST_CLEAR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
				if (rd_idx_q == LAST) begin
					st_d = slt_pkg::ST_IDLE;
				end
			end
			slt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.operation)
						slt_pkg::OP_INSERT: st_d = slt_pkg::ST_SCAN;
						slt_pkg::OP_LOOKUP: st_d = slt_pkg::ST_SCAN;
						slt_pkg::OP_REMOVE: begin
							st_d = pos_ok ? slt_pkg::ST_REM_RD : slt_pkg::ST_DONE;
						end
						default: st_d = slt_pkg::ST_DONE;
					endcase
				end
			end
			slt_pkg::ST_SCAN: begin
				if (scan_hit) begin
					if (op_q == slt_pkg::OP_INSERT) begin
						ram_en          = 1'b1;
						ram_we          = 1'b1;
						ram_addr        = chk_idx_q;
						ram_wd.valid    = 1'b1;
						ram_wd.value    = val_q;
					end
					st_d = slt_pkg::ST_DONE;
				end else if (chk_q && (chk_idx_q == LAST)) begin
					st_d = slt_pkg::ST_DONE;
				end else if (issue_q) begin
					ram_en = 1'b1;
				end
			end
			slt_pkg::ST_REM_RD: begin
				ram_en   = 1'b1;
				ram_addr = pos_q;
				st_d     = slt_pkg::ST_REM_CHK;
			end
			slt_pkg::ST_REM_CHK: begin
				if (ram_rd.valid) begin
					ram_en       = 1'b1;
					ram_we       = 1'b1;
					ram_addr     = pos_q;
					ram_wd.valid = 1'b0;
					ram_wd.value = ram_rd.value;
				end
				st_d = slt_pkg::ST_DONE;
			end
			slt_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					st_d = slt_pkg::ST_IDLE;
				end
			end
			default: st_d = slt_pkg::ST_IDLE;
		endcase
	end

	// Scan pointers and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			issue_q  <= 1'b0;
			chk_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			case (st_q)
				slt_pkg::ST_CLEAR: begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
				slt_pkg::ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						issue_q  <= 1'b1;
						chk_q    <= 1'b0;
					end
				end
				slt_pkg::ST_SCAN: begin
					if (scan_hit) begin
						if (op_q == slt_pkg::OP_INSERT) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end else begin
						chk_q <= issue_q;
						if (issue_q) begin
							rd_idx_q <= rd_idx_q + IW'(1);
							issue_q  <= (rd_idx_q != LAST);
						end
					end
				end
				slt_pkg::ST_REM_CHK: begin
					if (ram_rd.valid) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Request fields and result slot
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			val_q  <= req.value;
			pos_q  <= IW'(req.position);
			hit_q  <= 1'b0;
			slot_q <= '0;
		end
		if (st_q == slt_pkg::ST_SCAN) begin
			if (scan_hit) begin
				hit_q  <= 1'b1;
				slot_q <= chk_idx_q;
			end else begin
				chk_idx_q <= rd_idx_q;
			end
		end
		if ((st_q == slt_pkg::ST_REM_CHK) && ram_rd.valid) begin
			hit_q  <= 1'b1;
			slot_q <= pos_q;
		end
	end

	// Result word: slot and count reported in their low bits
	always_comb begin
		res.hit       = hit_q;
		res.count     = slt_pkg::CNT_W'(cnt_q);
		res.empty_res = (cnt_q == '0);
		if (!hit_q) begin
			res.slot = '0;
		end else begin
			res.slot = slt_pkg::SLOT_W'(slot_q);
		end
	end

endmodule
